>>> rtl/deadline_job_sequencer_macros.svh
// assertion macros shared by the deadline job sequencer rtl
`ifndef DEADLINE_JOB_SEQUENCER_MACROS_SVH
`define DEADLINE_JOB_SEQUENCER_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define DJS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define DJS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/djs_pkg.sv
// shared widths, limits and control structs of the deadline job sequencer
package djs_pkg;

   // field widths
   localparam int DL_W     = 8;
   localparam int PROFIT_W = 16;
   localparam int COUNT_W  = 9;
   localparam int TOTAL_W  = 24;

   // saturation limits of the result word
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [TOTAL_W-1:0] PROFIT_MAX = '1;

   // sequencer to selection unit controls
   typedef struct packed {
      logic clear_best;
      logic clear_limit;
      logic take_limit;
      logic cand_valid;
   } scan_ctrl_type;

   // best job found by the current selection pass
   typedef struct packed {
      logic                found;
      logic [PROFIT_W-1:0] profit;
      logic [DL_W-1:0]     deadline;
   } best_type;

endpackage

>>> rtl/deadline_job_sequencer.sv
// Deadline job sequencer. Jobs load at one word per cycle into a job ram while the
// block is loading (req_stall is high in every other state); the word with last set
// closes the set. The block then runs n selection passes over the stored jobs
// (n = jobs stored), where one shared comparator picks the best job ranked below
// the previous pick (profit, then deadline). Each pick probes the slot ram downward
// from its clamped deadline, one slot at a time, until a free slot is found or slot 1
// is passed. After the result word is taken, and after reset, a clearing pass over
// all MAX_DEADLINE+1 slots empties the slot ram; no job is accepted then.
`include "deadline_job_sequencer_macros.svh"

module deadline_job_sequencer #(
   parameter int MAX_JOBS     = 256,
   parameter int MAX_DEADLINE = 255
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [djs_pkg::DL_W-1:0]      req_deadline,
   input  logic [djs_pkg::PROFIT_W-1:0]  req_profit,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [djs_pkg::COUNT_W-1:0]   rsp_job_count,
   output logic [djs_pkg::TOTAL_W-1:0]   rsp_total_profit,
   output logic                         rsp_overflow
);
   import djs_pkg::*;

   localparam int JW = $clog2(MAX_JOBS);
   localparam int LW = $clog2(MAX_JOBS + 1);
   localparam int SW = $clog2(MAX_DEADLINE + 1);
   localparam int CW = (SW > DL_W) ? SW : DL_W;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_PICK   = 3'd3;
   localparam logic [2:0] S_PROBE  = 3'd4;
   localparam logic [2:0] S_CHECK  = 3'd5;
   localparam logic [2:0] S_NEXT   = 3'd6;
   localparam logic [2:0] S_RESULT = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [SW-1:0]      clear_ff, clear_in;
   logic [LW-1:0]      n_ff, n_in;
   logic               ovf_ff, ovf_in;
   logic [LW-1:0]      scan_ff, scan_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [JW-1:0]      rd_idx_ff, rd_idx_in;
   logic [LW-1:0]      picks_ff, picks_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic                     job_we;
   logic [DL_W+PROFIT_W-1:0] job_rd_data;
   logic                     slot_we;
   logic [SW-1:0]            slot_waddr;
   logic                     slot_wdata;
   logic                     slot_rd_data;

   scan_ctrl_type ctrl;
   best_type      best;

   logic [CW-1:0]      dl_wide;
   logic [CW-1:0]      dl_clamped;
   logic [SW-1:0]      dl_slot;
   logic [TOTAL_W:0]   total_sum;

   // job store: deadline and profit side by side
   djs_ram #(
      .WIDTH (DL_W + PROFIT_W),
      .DEPTH (MAX_JOBS)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (job_we),
      .wr_addr (n_ff[JW-1:0]),
      .wr_data ({req_deadline, req_profit}),
      .rd_addr (scan_ff[JW-1:0]),
      .rd_data (job_rd_data)
   );

   // slot occupancy store
   djs_ram #(
      .WIDTH (1),
      .DEPTH (MAX_DEADLINE + 1)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_ff),
      .rd_data (slot_rd_data)
   );

   // shared selection comparator
   djs_scan #(
      .IDX_W (JW)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .cand_idx      (rd_idx_ff),
      .cand_deadline (job_rd_data[PROFIT_W +: DL_W]),
      .cand_profit   (job_rd_data[PROFIT_W-1:0]),
      .best          (best)
   );

   // deadline clamp and saturating profit sum
   always_comb begin
      dl_wide    = CW'(best.deadline);
      dl_clamped = (dl_wide > CW'(MAX_DEADLINE)) ? CW'(MAX_DEADLINE) : dl_wide;
      dl_slot    = dl_clamped[SW-1:0];
      total_sum  = {1'b0, total_ff} + (TOTAL_W + 1)'(best.profit);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clear_in    = clear_ff;
      n_in        = n_ff;
      ovf_in      = ovf_ff;
      scan_in     = scan_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      picks_in    = picks_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      job_we      = 1'b0;
      slot_we     = 1'b0;
      slot_waddr  = clear_ff;
      slot_wdata  = 1'b0;
      ctrl        = '0;

      unique case (state_ff)
         S_CLEAR: begin
            slot_we = 1'b1;
            if (clear_ff == SW'(MAX_DEADLINE)) begin
               clear_in = '0;
               state_in = S_LOAD;
            end else begin
               clear_in = clear_ff + SW'(1);
            end
         end
         S_LOAD: begin
            if (req_valid) begin
               if (n_ff < LW'(MAX_JOBS)) begin
                  job_we = 1'b1;
                  n_in   = n_ff + LW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  scan_in          = '0;
                  picks_in         = '0;
                  ctrl.clear_best  = 1'b1;
                  ctrl.clear_limit = 1'b1;
                  state_in         = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            ctrl.cand_valid = rd_valid_ff;
            if (scan_ff < n_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = scan_ff[JW-1:0];
               scan_in     = scan_ff + LW'(1);
            end else if (!rd_valid_ff) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            picks_in        = picks_ff + LW'(1);
            ctrl.take_limit = 1'b1;
            if (best.found && (dl_slot != '0)) begin
               slot_in  = dl_slot;
               state_in = S_PROBE;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_PROBE: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!slot_rd_data) begin
               slot_we    = 1'b1;
               slot_waddr = slot_ff;
               slot_wdata = 1'b1;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               total_in = total_sum[TOTAL_W] ? PROFIT_MAX : total_sum[TOTAL_W-1:0];
               state_in = S_NEXT;
            end else if (slot_ff == SW'(1)) begin
               state_in = S_NEXT;
            end else begin
               slot_in  = slot_ff - SW'(1);
               state_in = S_PROBE;
            end
         end
         S_NEXT: begin
            if (picks_ff == n_ff) begin
               state_in = S_RESULT;
            end else begin
               scan_in         = '0;
               ctrl.clear_best = 1'b1;
               state_in        = S_SCAN;
            end
         end
         S_RESULT: begin
            if (!rsp_stall) begin
               clear_in = '0;
               n_in     = '0;
               ovf_in   = 1'b0;
               count_in = '0;
               total_in = '0;
               picks_in = '0;
               state_in = S_CLEAR;
            end
         end
      endcase
   end

   // control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clear_ff    <= '0;
         n_ff        <= '0;
         ovf_ff      <= 1'b0;
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
         picks_ff    <= '0;
         slot_ff     <= '0;
         count_ff    <= '0;
         total_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clear_ff    <= clear_in;
         n_ff        <= n_in;
         ovf_ff      <= ovf_in;
         scan_ff     <= scan_in;
         rd_valid_ff <= rd_valid_in;
         picks_ff    <= picks_in;
         slot_ff     <= slot_in;
         count_ff    <= count_in;
         total_ff    <= total_in;
      end
   end

   // index of the word coming out of the job ram
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
   end

   // handshake and result word
   assign req_stall        = (state_ff != S_LOAD);
   assign rsp_valid        = (state_ff == S_RESULT);
   assign rsp_job_count    = count_ff;
   assign rsp_total_profit = total_ff;
   assign rsp_overflow     = ovf_ff;

   // checks
   `DJS_ASSERT_IMPLIES(a_all_jobs_picked, rsp_valid, picks_ff == n_ff, "result before all jobs were ranked")
   `DJS_ASSERT_IMPLIES(a_probe_slot_nonzero, (state_ff == S_PROBE) || (state_ff == S_CHECK), slot_ff != '0, "slot zero probed")
   `DJS_ASSERT_NEXT(a_set_cleared, rsp_valid && !rsp_stall, (n_ff == '0) && (count_ff == '0) && !ovf_ff, "set state not cleared after result")
   `DJS_ASSERT_NEXT(a_overflow_seen, req_valid && !req_stall && (n_ff == LW'(MAX_JOBS)), ovf_ff, "dropped job did not raise overflow")

endmodule

>>> rtl/djs_ram.sv
// generic single-write, single-read ram with registered read data
module djs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/djs_scan.sv
// selection unit: finds the best job ranked strictly below the previous pick
module djs_scan #(
   parameter int IDX_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  djs_pkg::scan_ctrl_type      ctrl,
   input  logic [IDX_W-1:0]            cand_idx,
   input  logic [djs_pkg::DL_W-1:0]     cand_deadline,
   input  logic [djs_pkg::PROFIT_W-1:0] cand_profit,
   output djs_pkg::best_type           best
);
   import djs_pkg::*;

   // rank key: profit first, then deadline, then store index to break ties
   localparam int KW = PROFIT_W + DL_W + IDX_W;

   logic [KW-1:0] cand_key;
   logic          below_limit;
   logic          above_best;
   logic          take;

   logic          found_ff, found_in;
   logic          has_limit_ff, has_limit_in;
   logic [KW-1:0] best_key_ff, best_key_in;
   logic [KW-1:0] limit_ff, limit_in;

   assign cand_key = {cand_profit, cand_deadline, cand_idx};

   // shared compare against the limit and the running best
   always_comb begin
      below_limit = !has_limit_ff || (cand_key < limit_ff);
      above_best  = !found_ff || (cand_key > best_key_ff);
      take        = ctrl.cand_valid && below_limit && above_best;
   end

   // next values of best and limit
   always_comb begin
      found_in     = found_ff;
      best_key_in  = best_key_ff;
      has_limit_in = has_limit_ff;
      limit_in     = limit_ff;
      if (ctrl.clear_best) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in    = 1'b1;
         best_key_in = cand_key;
      end
      if (ctrl.clear_limit) begin
         has_limit_in = 1'b0;
      end else if (ctrl.take_limit && found_ff) begin
         has_limit_in = 1'b1;
         limit_in     = best_key_ff;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         has_limit_ff <= 1'b0;
      end else begin
         found_ff     <= found_in;
         has_limit_ff <= has_limit_in;
      end
   end

   // key payload
   always_ff @(posedge clock) begin
      best_key_ff <= best_key_in;
      limit_ff    <= limit_in;
   end

   always_comb begin
      best.found    = found_ff;
      best.profit   = best_key_ff[KW-1 -: PROFIT_W];
      best.deadline = best_key_ff[IDX_W +: DL_W];
   end

endmodule
